>>> rtl/core/motor_current_moving_average_defines.svh
// Assertion macros for the motor current moving average block.
// No dependencies; the including module must have clk and rst_n in scope.
`ifndef MOTOR_CURRENT_MOVING_AVERAGE_DEFINES_SVH
`define MOTOR_CURRENT_MOVING_AVERAGE_DEFINES_SVH

// Same-cycle implication, checked out of reset.
`define MCA_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked out of reset.
`define MCA_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

// Invariant, checked out of reset.
`define MCA_ASSERT_ALWAYS(lbl, expr, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (expr)) \
    else $error(msg);

`endif

>>> rtl/core/mca_pkg.sv
// Shared types and constants for the motor current moving average block.
// No dependencies.
package mca_pkg;

  localparam int SAMPLE_W   = 12;
  localparam int OFFSET_W   = 12;
  localparam int GAIN_W     = 16;
  localparam int OUT_W      = 23;
  localparam int PROD_W     = 22;  // 4095 * 1000 fits in 22 bits
  localparam int DVS_W      = 16;  // divisor: gain, or sample count up to WINDOW_LEN
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 16;

  localparam logic [PROD_W-1:0] SCALE_MA = 22'd1000;

  // config register indexes
  localparam logic [CFG_IDX_W-1:0] REG_ADC_OFFSET = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_ADC_GAIN   = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_KEEP_SIGN  = 2'd2;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MUL,
    ST_SDIV,
    ST_SWAIT,
    ST_UPD,
    ST_ADIV,
    ST_AWAIT,
    ST_OUT
  } ctrl_state_t;

  typedef struct packed {
    logic load;       // capture sample, apply restart
    logic mul;        // scale by 1000, fetch oldest ring entry
    logic div_start;  // launch divider
    logic div_avg;    // 1: average division, 0: milliamp scaling
    logic cur_load;   // capture instant current from quotient
    logic upd;        // ring write, total and slot update
    logic out_load;   // load result register
  } dp_cmd_t;

  typedef struct packed {
    logic div_busy;
    logic div_done;
    logic out_free;
  } dp_sts_t;

endpackage

>>> rtl/core/motor_current_moving_average.sv
// Motor current moving average, one sample at a time through a shared divider.
// Each sample goes through two bit-serial divisions (milliamp scaling, then
// average) in one shared divider; a new beat is taken only once the last
// sample has been handed to the result register. Reset (rst_n low, synchronous)
// clears slot, total and full mark, sets the count to 1 and config to offset 0,
// gain 1, magnitude mode; ring contents are not cleared.
`include "motor_current_moving_average_defines.svh"

module motor_current_moving_average import mca_pkg::*; #(
  parameter int WINDOW_LEN = 16
) (
  input  logic                    clk,
  input  logic                    rst_n,
  // config write channel
  input  logic                    cfg_valid,
  output logic                    cfg_ready,
  input  logic [CFG_IDX_W-1:0]    cfg_index,
  input  logic [CFG_DATA_W-1:0]   cfg_data,
  // sample channel
  input  logic                    in_valid,
  output logic                    in_ready,
  input  logic [SAMPLE_W-1:0]     in_raw_sample,
  input  logic                    in_restart,
  // result channel
  output logic                    out_valid,
  input  logic                    out_ready,
  output logic signed [OUT_W-1:0] out_current_ma,
  output logic signed [OUT_W-1:0] out_average_ma
);

  // Controller and datapath talk only through these two bundles.
  dp_cmd_t cmd;
  dp_sts_t sts;

  // Sequencer: IDLE takes a beat, then scale multiply, scaling divide,
  // ring/total update, average divide, and a hand-off into the result
  // register. The result register decouples the output side, so the next
  // beat is taken while a finished result still waits for out_ready.
  mca_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  // Datapath: offset removal and abs, x1000, divide by gain (truncating
  // toward zero via magnitude divide and sign fix-up), ring of the last
  // WINDOW_LEN results with a running total, divide by count or window.
  mca_dp #(
    .WINDOW_LEN (WINDOW_LEN)
  ) u_dp (
    .clk            (clk),
    .rst_n          (rst_n),
    .cmd            (cmd),
    .sts            (sts),
    .cfg_valid      (cfg_valid),
    .cfg_ready      (cfg_ready),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data),
    .in_raw_sample  (in_raw_sample),
    .in_restart     (in_restart),
    .out_ready      (out_ready),
    .out_valid      (out_valid),
    .out_current_ma (out_current_ma),
    .out_average_ma (out_average_ma)
  );

  // strobes that act on the datapath; at most one per cycle
  logic [5:0] cmd_strobe;
  assign cmd_strobe = {cmd.load, cmd.mul, cmd.div_start, cmd.cur_load, cmd.upd, cmd.out_load};

  // Checks on the sequencing.
  `MCA_ASSERT_IMP(a_div_start_idle, cmd.div_start, !sts.div_busy, "divider restarted while busy")
  `MCA_ASSERT_IMP(a_no_result_overwrite, cmd.out_load, sts.out_free, "unread result overwritten")
  `MCA_ASSERT_NXT(a_one_at_a_time, in_valid && in_ready, !in_ready, "beat taken while busy")
  `MCA_ASSERT_ALWAYS(a_cmd_onehot, $onehot0(cmd_strobe), "overlapping commands")

endmodule

>>> rtl/core/mca_div.sv
// Restoring unsigned divider, one quotient bit per cycle.
// Depends on mca_pkg.
module mca_div import mca_pkg::*; #(
  parameter int DVD_W = 26
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             start,
  input  logic [DVD_W-1:0] dividend,
  input  logic [DVS_W-1:0] divisor,
  output logic             busy,
  output logic             done,
  output logic [DVD_W-1:0] quotient
);

  localparam int CNT_W = $clog2(DVD_W);
  localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(DVD_W - 1);

  logic             busy_r;
  logic             done_r;
  logic [CNT_W-1:0] cnt_r;
  logic [DVS_W-1:0] rem_r;
  logic [DVS_W-1:0] dvs_r;
  logic [DVD_W-1:0] quo_r;

  logic [DVS_W:0]   shift;
  logic [DVS_W:0]   trial;
  logic             ge;
  logic [DVS_W-1:0] rem_nxt;

  assign shift   = {rem_r, quo_r[DVD_W-1]};
  assign trial   = shift - {1'b0, dvs_r};
  assign ge      = (shift >= {1'b0, dvs_r});
  assign rem_nxt = ge ? trial[DVS_W-1:0] : shift[DVS_W-1:0];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= '0;
      end else if (busy_r) begin
        cnt_r <= cnt_r + 1'b1;
        if (cnt_r == CNT_LAST) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      quo_r <= dividend;
      rem_r <= '0;
      dvs_r <= divisor;
    end else if (busy_r) begin
      quo_r <= {quo_r[DVD_W-2:0], ge};
      rem_r <= rem_nxt;
    end
  end

  assign busy     = busy_r;
  assign done     = done_r;
  assign quotient = quo_r;

endmodule

>>> rtl/core/mca_dp.sv
// Datapath: config registers, offset/abs/scale, history ring, running total,
// shared divider and result register. Depends on mca_pkg and mca_div.
module mca_dp import mca_pkg::*; #(
  parameter int WINDOW_LEN = 16
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  dp_cmd_t                      cmd,
  output dp_sts_t                      sts,
  input  logic                         cfg_valid,
  output logic                         cfg_ready,
  input  logic [CFG_IDX_W-1:0]         cfg_index,
  input  logic [CFG_DATA_W-1:0]        cfg_data,
  input  logic [SAMPLE_W-1:0]          in_raw_sample,
  input  logic                         in_restart,
  input  logic                         out_ready,
  output logic                         out_valid,
  output logic signed [OUT_W-1:0]      out_current_ma,
  output logic signed [OUT_W-1:0]      out_average_ma
);

  localparam int IDX_W   = $clog2(WINDOW_LEN);
  localparam int CNT_W   = $clog2(WINDOW_LEN + 1);
  localparam int TOTAL_W = OUT_W + IDX_W;
  localparam int DVD_W   = TOTAL_W - 1;

  // config
  logic [OFFSET_W-1:0] adc_offset_r;
  logic [GAIN_W-1:0]   adc_gain_r;
  logic                keep_sign_r;

  // per-sample
  logic [SAMPLE_W-1:0]     mag_r;
  logic                    neg_r;
  logic [PROD_W-1:0]       prod_r;
  logic signed [OUT_W-1:0] old_r;
  logic signed [OUT_W-1:0] cur_r;
  logic                    qneg_r;

  // history
  logic signed [OUT_W-1:0]   ring [WINDOW_LEN];
  logic signed [TOTAL_W-1:0] total_r;
  logic [IDX_W-1:0]          slot_r;
  logic                      full_r;
  logic [CNT_W-1:0]          avg_cnt_r;

  // result
  logic                    out_valid_r;
  logic signed [OUT_W-1:0] out_cur_r;
  logic signed [OUT_W-1:0] out_avg_r;

  logic signed [SAMPLE_W:0]  diff;
  logic [SAMPLE_W:0]         diff_abs;
  logic signed [TOTAL_W-1:0] total_nxt;
  logic signed [TOTAL_W-1:0] old_ext;
  logic signed [TOTAL_W-1:0] cur_ext;
  logic [TOTAL_W-1:0]        total_mag;
  logic                      wrap;
  logic [DVD_W-1:0]          div_dvd;
  logic [DVS_W-1:0]          div_dvs;
  logic [DVS_W-1:0]          gain_eff;
  logic                      div_busy;
  logic                      div_done;
  logic [DVD_W-1:0]          quo;
  logic signed [OUT_W-1:0]   q_s;
  logic signed [OUT_W-1:0]   q_signed;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      adc_offset_r <= '0;
      adc_gain_r   <= GAIN_W'(1);
      keep_sign_r  <= 1'b0;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        REG_ADC_OFFSET: adc_offset_r <= cfg_data[OFFSET_W-1:0];
        REG_ADC_GAIN:   adc_gain_r   <= cfg_data[GAIN_W-1:0];
        REG_KEEP_SIGN:  keep_sign_r  <= cfg_data[0];
        default: ;
      endcase
    end
  end

  // offset removal and magnitude
  assign diff     = $signed({1'b0, in_raw_sample}) - $signed({1'b0, adc_offset_r});
  assign diff_abs = diff[SAMPLE_W] ? -diff : diff;

  // running total update: drop oldest once full, add newest
  assign old_ext   = {{(TOTAL_W-OUT_W){old_r[OUT_W-1]}}, old_r};
  assign cur_ext   = {{(TOTAL_W-OUT_W){cur_r[OUT_W-1]}}, cur_r};
  assign total_nxt = total_r - (full_r ? old_ext : '0) + cur_ext;
  assign wrap      = (slot_r == IDX_W'(WINDOW_LEN - 1));

  assign total_mag = total_r[TOTAL_W-1] ? -total_r : total_r;
  assign gain_eff  = (adc_gain_r == '0) ? DVS_W'(1) : DVS_W'(adc_gain_r);
  assign div_dvd   = cmd.div_avg ? total_mag[DVD_W-1:0] : DVD_W'(prod_r);
  assign div_dvs   = cmd.div_avg ? DVS_W'(avg_cnt_r) : gain_eff;

  assign q_s      = signed'(quo[OUT_W-1:0]);
  assign q_signed = qneg_r ? -q_s : q_s;

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      mag_r <= diff_abs[SAMPLE_W-1:0];
      neg_r <= keep_sign_r & diff[SAMPLE_W];
    end
    if (cmd.mul) begin
      prod_r <= PROD_W'(mag_r) * SCALE_MA;
    end
    if (cmd.div_start) begin
      qneg_r <= cmd.div_avg ? total_r[TOTAL_W-1] : neg_r;
    end
    if (cmd.cur_load) begin
      cur_r <= q_signed;
    end
    if (cmd.out_load) begin
      out_cur_r <= cur_r;
      out_avg_r <= q_signed;
    end
  end

  // history ring
  always_ff @(posedge clk) begin
    if (cmd.mul) begin
      old_r <= ring[slot_r];
    end
    if (cmd.upd) begin
      ring[slot_r] <= cur_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      total_r   <= '0;
      slot_r    <= '0;
      full_r    <= 1'b0;
      avg_cnt_r <= CNT_W'(1);
    end else if (cmd.load && in_restart) begin
      total_r <= '0;
      slot_r  <= '0;
      full_r  <= 1'b0;
    end else if (cmd.upd) begin
      total_r   <= total_nxt;
      slot_r    <= wrap ? '0 : slot_r + 1'b1;
      full_r    <= full_r | wrap;
      avg_cnt_r <= (full_r | wrap) ? CNT_W'(WINDOW_LEN) : CNT_W'(slot_r) + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.out_load) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  mca_div #(
    .DVD_W (DVD_W)
  ) u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (cmd.div_start),
    .dividend (div_dvd),
    .divisor  (div_dvs),
    .busy     (div_busy),
    .done     (div_done),
    .quotient (quo)
  );

  assign sts.div_busy = div_busy;
  assign sts.div_done = div_done;
  assign sts.out_free = !out_valid_r || out_ready;

  assign out_valid      = out_valid_r;
  assign out_current_ma = out_cur_r;
  assign out_average_ma = out_avg_r;

endmodule

>>> rtl/core/mca_ctrl.sv
// Sequencer: steps one sample through scale, ring update and averaging.
// Depends on mca_pkg.
module mca_ctrl import mca_pkg::*; (
  input  logic    clk,
  input  logic    rst_n,
  input  logic    in_valid,
  output logic    in_ready,
  input  dp_sts_t sts,
  output dp_cmd_t cmd
);

  ctrl_state_t state_r;
  ctrl_state_t state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    in_ready  = 1'b0;
    unique case (state_r)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load  = 1'b1;
          state_nxt = ST_MUL;
        end
      end
      ST_MUL: begin
        cmd.mul   = 1'b1;
        state_nxt = ST_SDIV;
      end
      ST_SDIV: begin
        cmd.div_start = 1'b1;
        state_nxt     = ST_SWAIT;
      end
      ST_SWAIT: begin
        if (sts.div_done) begin
          cmd.cur_load = 1'b1;
          state_nxt    = ST_UPD;
        end
      end
      ST_UPD: begin
        cmd.upd   = 1'b1;
        state_nxt = ST_ADIV;
      end
      ST_ADIV: begin
        cmd.div_start = 1'b1;
        cmd.div_avg   = 1'b1;
        state_nxt     = ST_AWAIT;
      end
      ST_AWAIT: begin
        cmd.div_avg = 1'b1;
        if (sts.div_done) begin
          state_nxt = ST_OUT;
        end
      end
      ST_OUT: begin
        cmd.div_avg = 1'b1;
        if (sts.out_free) begin
          cmd.out_load = 1'b1;
          state_nxt    = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

endmodule
